### rtl/core/sra_pkg.sv
// Package for the skyline rectangle allocator: sizes, codes and shared types.
// No dependencies.
package sra_pkg;

  localparam int unsigned MaxSegments = 512;
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned DimW = 13;
  localparam int unsigned PosW = 12;
  // one memory word holds x, height and width of a segment
  localparam int unsigned SegW = 3 * DimW;

  localparam logic [DimW-1:0] AtlasResetVal = DimW'(512);

  typedef enum logic [1:0] {
    StPlaced  = 2'd0,
    StNoFit   = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef enum logic {
    RegAtlasWidth  = 1'b0,
    RegAtlasHeight = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KindAlloc = 1'b0,
    KindReset = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    FsmInit,
    FsmIdle,
    FsmOuterRd,
    FsmOuterWait,
    FsmInnerRd,
    FsmInnerWait,
    FsmInnerEval,
    FsmShiftRd,
    FsmShiftWait,
    FsmInsert,
    FsmTrimRd,
    FsmTrimWait,
    FsmTrimEval,
    FsmRemRd,
    FsmRemWait,
    FsmDone
  } fsm_e;

  typedef struct packed {
    logic       [DimW-1:0] x;
    logic       [DimW-1:0] h;
    logic       [DimW-1:0] w;
  } seg_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start;       // latch item, reset result
    logic do_clear;    // skyline reset
    logic init_fail;   // zero size
    logic outer_rd;    // read segment i
    logic outer_eval;  // capture base of candidate i, start inner walk
    logic inner_rd;    // read segment j
    logic inner_eval;  // accumulate segment j
    logic cand_eval;   // judge candidate i
    logic outer_next;  // advance i
    logic finish_scan; // decide found / full
    logic shift_rd;    // read segment j-1
    logic shift_wr;    // write it to j
    logic insert;      // write new segment, count++
    logic trim_rd;     // read segment j
    logic trim_eval;   // trim or start removal
    logic rem_rd;      // read segment k+1
    logic rem_wr;      // write it to k
    logic rem_done;    // count--
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_size;
    logic outer_more;  // i < count
    logic skip_cand;   // x + w > atlas_width
    logic inner_more;  // j < count && acc < w (after eval)
    logic found;
    logic full;
    logic shift_more;  // j > best
    logic trim_go;     // j < count && x[j] < right
    logic trim_remove; // width <= shrink
    logic rem_more;    // k+1 < count
  } stat_t;

endpackage

### rtl/core/sra_if.sv
// Valid/ready channel interface with source and sink modports.
// Uses sra_pkg only through its payload type parameter.
interface sra_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sra_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write one word and read the word at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/core/sra_ctrl.sv
// Controller state machine of the skyline allocator.
// Depends on sra_pkg.
module sra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_kind_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sra_pkg::stat_t stat_i,
  output sra_pkg::cmd_t  cmd_o
);
  import sra_pkg::*;

  fsm_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmInit;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      FsmInit: begin
        // write the single full-width segment once after reset
        cmd_o.do_clear = 1'b1;
        state_d = FsmIdle;
      end
      FsmIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (in_kind_i == KindReset) begin
            cmd_o.do_clear = 1'b1;
            state_d = FsmDone;
          end else begin
            state_d = FsmOuterRd;
          end
        end
      end
      FsmOuterRd: begin
        if (stat_i.zero_size) begin
          cmd_o.init_fail = 1'b1;
          state_d = FsmDone;
        end else if (stat_i.outer_more) begin
          cmd_o.outer_rd = 1'b1;
          state_d = FsmOuterWait;
        end else begin
          cmd_o.finish_scan = 1'b1;
          state_d = (stat_i.found && !stat_i.full) ? FsmShiftRd : FsmDone;
        end
      end
      FsmOuterWait: begin
        cmd_o.outer_eval = 1'b1;
        if (stat_i.skip_cand) begin
          cmd_o.outer_next = 1'b1;
          state_d = FsmOuterRd;
        end else begin
          state_d = FsmInnerRd;
        end
      end
      FsmInnerRd: begin
        cmd_o.inner_rd = 1'b1;
        state_d = FsmInnerWait;
      end
      FsmInnerWait: begin
        cmd_o.inner_eval = 1'b1;
        state_d = FsmInnerEval;
      end
      FsmInnerEval: begin
        if (stat_i.inner_more) begin
          state_d = FsmInnerRd;
        end else begin
          cmd_o.cand_eval  = 1'b1;
          cmd_o.outer_next = 1'b1;
          state_d = FsmOuterRd;
        end
      end
      FsmShiftRd: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d = FsmShiftWait;
        end else begin
          state_d = FsmInsert;
        end
      end
      FsmShiftWait: begin
        cmd_o.shift_wr = 1'b1;
        state_d = FsmShiftRd;
      end
      FsmInsert: begin
        cmd_o.insert = 1'b1;
        state_d = FsmTrimRd;
      end
      FsmTrimRd: begin
        cmd_o.trim_rd = 1'b1;
        state_d = FsmTrimWait;
      end
      FsmTrimWait: begin
        // keep the address on segment j so the evaluation sees it
        cmd_o.trim_rd = 1'b1;
        state_d = FsmTrimEval;
      end
      FsmTrimEval: begin
        if (!stat_i.trim_go) begin
          state_d = FsmDone;
        end else begin
          cmd_o.trim_eval = 1'b1;
          state_d = stat_i.trim_remove ? FsmRemRd : FsmDone;
        end
      end
      FsmRemRd: begin
        if (stat_i.rem_more) begin
          cmd_o.rem_rd = 1'b1;
          state_d = FsmRemWait;
        end else begin
          cmd_o.rem_done = 1'b1;
          state_d = FsmTrimRd;
        end
      end
      FsmRemWait: begin
        cmd_o.rem_wr = 1'b1;
        state_d = FsmRemRd;
      end
      FsmDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end
endmodule

### rtl/core/sra_dp.sv
// Datapath of the skyline allocator: segment memory, scan and edit registers.
// Depends on sra_pkg and sra_ram.
module sra_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sra_pkg::cmd_t            cmd_i,
  output sra_pkg::stat_t           stat_o,
  input  logic [sra_pkg::DimW-1:0] in_w_i,
  input  logic [sra_pkg::DimW-1:0] in_h_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sra_pkg::DimW-1:0] cfg_data_i,
  output logic [1:0]               status_o,
  output logic [sra_pkg::PosW-1:0] place_x_o,
  output logic [sra_pkg::PosW-1:0] place_y_o
);
  import sra_pkg::*;

  logic [DimW-1:0] aw_q, ah_q;
  logic [CntW-1:0] cnt_q;
  logic [DimW-1:0] w_q, h_q;
  logic [CntW-1:0] i_q, j_q;
  logic [DimW-1:0] bx_q, bw_q;
  logic [DimW-1:0] cy_q;
  logic [DimW:0]   acc_q;
  logic            found_q;
  logic [CntW-1:0] best_q;
  logic [DimW-1:0] best_y_q, best_w_q, best_x_q;
  logic [DimW:0]   right_q;
  logic [1:0]      status_q;
  logic [PosW-1:0] px_q, py_q;

  logic            we;
  logic [IdxW-1:0] addr;
  seg_t            wseg, rseg;
  logic [DimW+1:0] fit_x, fit_y;
  logic [DimW:0]   shrink;

  sra_ram #(.Width(SegW), .Depth(MaxSegments)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wseg),
    .rdata_o(rseg)
  );

  // memory port: one access a cycle
  always_comb begin
    we   = 1'b0;
    addr = i_q[IdxW-1:0];
    wseg = rseg;
    if (cmd_i.do_clear) begin
      we   = 1'b1;
      addr = '0;
      wseg = '{x: '0, h: '0, w: aw_q};
    end else if (cmd_i.inner_rd || cmd_i.trim_rd) begin
      addr = j_q[IdxW-1:0];
    end else if (cmd_i.shift_rd) begin
      addr = IdxW'(j_q - 1'b1);
    end else if (cmd_i.shift_wr || cmd_i.rem_wr) begin
      we   = 1'b1;
      addr = j_q[IdxW-1:0];
    end else if (cmd_i.rem_rd) begin
      addr = IdxW'(j_q + 1'b1);
    end else if (cmd_i.insert) begin
      we   = 1'b1;
      addr = best_q[IdxW-1:0];
      wseg = '{x: best_x_q, h: DimW'(best_y_q + h_q), w: w_q};
    end else if (cmd_i.trim_eval && !stat_o.trim_remove) begin
      we   = 1'b1;
      wseg = '{x: DimW'(right_q), h: rseg.h, w: DimW'({1'b0, rseg.w} - shrink)};
      addr = j_q[IdxW-1:0];
    end
  end

  assign fit_x  = {2'b0, rseg.x} + {2'b0, w_q};
  assign fit_y  = {2'b0, cy_q} + {2'b0, h_q};
  assign shrink = right_q - {1'b0, rseg.x};

  // status toward the controller
  always_comb begin
    stat_o.zero_size   = (w_q == '0) || (h_q == '0);
    stat_o.outer_more  = i_q < cnt_q;
    stat_o.skip_cand   = fit_x > {2'b0, aw_q};
    stat_o.inner_more  = (j_q < cnt_q) && (acc_q < {1'b0, w_q});
    stat_o.found       = found_q;
    stat_o.full        = cnt_q >= CntW'(MaxSegments);
    stat_o.shift_more  = j_q > best_q;
    stat_o.trim_go     = (j_q < cnt_q) && ({1'b0, rseg.x} < right_q);
    stat_o.trim_remove = {1'b0, rseg.w} <= shrink;
    stat_o.rem_more    = (j_q + 1'b1) < cnt_q;
  end

  // configuration registers and segment count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q    <= AtlasResetVal;
      ah_q    <= AtlasResetVal;
      cnt_q   <= CntW'(1);
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegAtlasWidth) aw_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == RegAtlasHeight) ah_q <= cfg_data_i;
      if (cmd_i.do_clear) cnt_q <= CntW'(1);
      if (cmd_i.insert) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.rem_done) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.start) found_q <= 1'b0;
      if (cmd_i.cand_eval && (acc_q >= {1'b0, w_q}) && (fit_y <= {2'b0, ah_q}) &&
          (!found_q || cy_q < best_y_q || (cy_q == best_y_q && bw_q < best_w_q))) begin
        found_q <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q      <= in_w_i;
      h_q      <= in_h_i;
      i_q      <= '0;
      status_q <= StPlaced;
      px_q     <= '0;
      py_q     <= '0;
    end
    if (cmd_i.init_fail) status_q <= StNoFit;
    if (cmd_i.outer_eval) begin
      bx_q  <= rseg.x;
      bw_q  <= rseg.w;
      cy_q  <= rseg.h;
      acc_q <= '0;
      j_q   <= i_q;
    end
    if (cmd_i.inner_eval) begin
      if (rseg.h > cy_q) cy_q <= rseg.h;
      acc_q <= acc_q + {1'b0, rseg.w};
      j_q   <= j_q + 1'b1;
    end
    if (cmd_i.cand_eval && (acc_q >= {1'b0, w_q}) && (fit_y <= {2'b0, ah_q}) &&
        (!found_q || cy_q < best_y_q || (cy_q == best_y_q && bw_q < best_w_q))) begin
      best_q   <= i_q;
      best_y_q <= cy_q;
      best_w_q <= bw_q;
      best_x_q <= bx_q;
    end
    if (cmd_i.outer_next) i_q <= i_q + 1'b1;
    if (cmd_i.finish_scan) begin
      j_q <= cnt_q;
      if (!found_q) begin
        status_q <= StNoFit;
      end else if (stat_o.full) begin
        status_q <= StFull;
      end else begin
        px_q    <= best_x_q[PosW-1:0];
        py_q    <= best_y_q[PosW-1:0];
        right_q <= {1'b0, best_x_q} + {1'b0, w_q};
      end
    end
    if (cmd_i.shift_wr) j_q <= j_q - 1'b1;
    if (cmd_i.insert) j_q <= best_q + 1'b1;
    if (cmd_i.rem_wr) j_q <= j_q + 1'b1;
    if (cmd_i.trim_eval && stat_o.trim_remove) begin
      i_q <= j_q;
    end
    if (cmd_i.rem_done) j_q <= i_q;
  end

  assign status_o  = status_q;
  assign place_x_o = px_q;
  assign place_y_o = py_q;
endmodule

### rtl/core/skyline_rect_allocator.sv
// Top level of the skyline rectangle allocator.
// Depends on sra_pkg, sra_if, sra_ctrl and sra_dp.
//
//   channel   dir  payload                        transfer
//   in_if     in   kind, rect_width, rect_height  valid & ready
//   out_if    out  status, place_x, place_y       valid & ready
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i high
//
// One item at a time. An allocate walks every segment i and, where the item
// fits within the atlas width from there, the following segments until the
// width is covered, each read going through the single segment memory port,
// then shifts the table up, inserts and trims. After reset the Init state
// writes the single full-width segment before input is taken. A result
// waiting on out_ready_i holds the block.
module skyline_rect_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sra_if.sink                      in_if,
  sra_if.source                    out_if,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sra_pkg::DimW-1:0] cfg_data_i
);
  import sra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.data.kind),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sra_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_w_i    (in_if.data.rect_width),
    .in_h_i    (in_if.data.rect_height),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .status_o  (out_if.data.status),
    .place_x_o (out_if.data.place_x),
    .place_y_o (out_if.data.place_y)
  );
endmodule

### rtl/core/sra_checker.sv
// Port-level checker for the skyline allocator, bound to the top level.
// Depends on sra_pkg.
module sra_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [11:0] place_x,
  input logic [11:0] place_y
);
  import sra_pkg::*;

  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  // hold off input the cycle after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("busy flag missing after transfer");
  // failures carry zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status != StPlaced) |-> (place_x == '0 && place_y == '0))
    else $error("failure with nonzero position");
  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("stalled result changed");
endmodule

bind skyline_rect_allocator sra_checker u_sra_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .status   (out_if.data.status),
  .place_x  (out_if.data.place_x),
  .place_y  (out_if.data.place_y)
);
